// ===== rtl/btmx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package btmx_pkg;

   localparam int KEY_BITS   = 31;
   localparam int NODE_COUNT = 65536;
   localparam int FIELD_BITS = 31;

   localparam int IDX_BITS   = $clog2(NODE_COUNT);
   localparam int USED_BITS  = $clog2(NODE_COUNT + 1);
   localparam int CNT_BITS   = $clog2(KEY_BITS);

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef struct packed {
      logic                  opcode;
      logic [FIELD_BITS-1:0] key;
   } req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] best_xor;
      logic [FIELD_BITS-1:0] running_best;
      logic                  refused;
   } rsp_type;

   typedef struct packed {
      logic                vld;
      logic [IDX_BITS-1:0] idx;
   } link_type;

   typedef link_type [1:0] entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

endpackage

`default_nettype wire

// ===== rtl/btmx_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module btmx_ram #(
   parameter int ADDR_BITS = 16,
   parameter int DATA_BITS = 34
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem_ff [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/binary_trie_max_xor_top.sv =====
// An accepted request walks the trie in ST_WALK, one trie level per cycle through the node
// table's read port; an insert that allocates the leaf node then passes ST_LEAF to clear it.
// ST_DONE registers the response, waiting while the previous response is still held back by
// rsp_ready; a refused insert goes straight to ST_DONE. A new request is taken only in ST_IDLE.
// Reset clears root links, node count, running maximum and handshake state; the node
// table is not cleared, since every node entry is written when the node is allocated.
`timescale 1ns / 1ps
`default_nettype none

module binary_trie_max_xor_top
   import btmx_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_LEAF, ST_DONE} state_type;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [KEY_BITS-1:0]   key_sr_ff, key_sr_in;
   logic [KEY_BITS-1:0]   res_sr_ff, res_sr_in;
   entry_type             root_ff, root_in;
   logic                  cur_root_ff, cur_root_in;
   logic [IDX_BITS-1:0]   cur_idx_ff, cur_idx_in;
   logic                  fresh_ff, fresh_in;
   logic                  dead_ff, dead_in;
   logic                  op_ff, op_in;
   logic                  refused_ff, refused_in;
   logic [USED_BITS-1:0]  nodes_used_ff, nodes_used_in;
   logic [FIELD_BITS-1:0] best_seen_ff, best_seen_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  ram_wr_en;
   logic [IDX_BITS-1:0]   ram_wr_addr;
   entry_type             ram_wr_data;
   logic [IDX_BITS-1:0]   ram_rd_addr;
   logic [ENTRY_BITS-1:0] ram_rd_data;

   entry_type             entry;
   entry_type             upd;
   link_type              other_lk;
   link_type              same_lk;
   logic                  b;
   logic                  res_bit;
   logic [IDX_BITS-1:0]   nxt;
   logic                  pool_low;
   logic [FIELD_BITS-1:0] best;

   btmx_ram #(
      .ADDR_BITS (IDX_BITS),
      .DATA_BITS (ENTRY_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign b        = key_sr_ff[KEY_BITS-1];
   assign entry    = cur_root_ff ? root_ff : (fresh_ff ? entry_type'('0) : entry_type'(ram_rd_data));
   assign other_lk = entry[~b];
   assign same_lk  = entry[b];
   assign pool_low = (USED_BITS'(NODE_COUNT) - nodes_used_ff) < USED_BITS'(KEY_BITS);
   assign best     = FIELD_BITS'(res_sr_ff);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      key_sr_in     = key_sr_ff;
      res_sr_in     = res_sr_ff;
      root_in       = root_ff;
      cur_root_in   = cur_root_ff;
      cur_idx_in    = cur_idx_ff;
      fresh_in      = fresh_ff;
      dead_in       = dead_ff;
      op_in         = op_ff;
      refused_in    = refused_ff;
      nodes_used_in = nodes_used_ff;
      best_seen_in  = best_seen_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cur_idx_ff;
      ram_wr_data   = '0;
      ram_rd_addr   = cur_idx_ff;
      upd           = entry;
      res_bit       = 1'b0;
      nxt           = cur_idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in       = req_data.opcode;
               key_sr_in   = req_data.key[KEY_BITS-1:0];
               res_sr_in   = '0;
               cnt_in      = CNT_BITS'(KEY_BITS - 1);
               cur_root_in = 1'b1;
               fresh_in    = 1'b0;
               dead_in     = 1'b0;
               refused_in  = 1'b0;
               if (req_data.opcode == OP_INSERT && pool_low) begin
                  refused_in = 1'b1;
                  state_in   = ST_DONE;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            key_sr_in   = key_sr_ff << 1;
            cnt_in      = cnt_ff - CNT_BITS'(1);
            cur_root_in = 1'b0;
            if (op_ff == OP_QUERY) begin
               if (!dead_ff) begin
                  if (other_lk.vld) begin
                     res_bit = 1'b1;
                     nxt     = other_lk.idx;
                  end else if (same_lk.vld) begin
                     nxt = same_lk.idx;
                  end else begin
                     dead_in = 1'b1;
                  end
               end
               res_sr_in = {res_sr_ff[KEY_BITS-2:0], res_bit};
            end else begin
               if (!fresh_ff && same_lk.vld) begin
                  nxt = same_lk.idx;
               end else begin
                  nxt        = nodes_used_ff[IDX_BITS-1:0];
                  upd[b]     = '{vld: 1'b1, idx: nxt};
                  fresh_in   = 1'b1;
                  nodes_used_in = nodes_used_ff + USED_BITS'(1);
                  if (cur_root_ff) begin
                     root_in = upd;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = upd;
                  end
               end
            end
            cur_idx_in  = nxt;
            ram_rd_addr = nxt;
            if (cnt_ff == '0) begin
               state_in = (op_ff == OP_INSERT && fresh_in) ? ST_LEAF : ST_DONE;
            end
         end
         ST_LEAF: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = '0;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (op_ff == OP_QUERY && best > best_seen_ff) begin
                  best_seen_in = best;
               end
               rsp_in.best_xor     = best;
               rsp_in.running_best = best_seen_in;
               rsp_in.refused      = refused_ff;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         root_ff       <= '0;
         nodes_used_ff <= '0;
         best_seen_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         dead_ff       <= 1'b0;
         fresh_ff      <= 1'b0;
         cur_root_ff   <= 1'b1;
      end else begin
         state_ff      <= state_in;
         root_ff       <= root_in;
         nodes_used_ff <= nodes_used_in;
         best_seen_ff  <= best_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
         dead_ff       <= dead_in;
         fresh_ff      <= fresh_in;
         cur_root_ff   <= cur_root_in;
      end
      cnt_ff     <= cnt_in;
      key_sr_ff  <= key_sr_in;
      res_sr_ff  <= res_sr_in;
      cur_idx_ff <= cur_idx_in;
      op_ff      <= op_in;
      refused_ff <= refused_in;
      rsp_ff     <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/btmx_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

module btmx_check
   import btmx_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // hold the result until the transaction completes
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new transaction taken while one is in flight");

   a_best_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.best_xor <= rsp_data.running_best)
      else $error("best_xor exceeds running maximum");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.refused |-> rsp_data.best_xor == '0)
      else $error("refused insert carries nonzero best_xor");

endmodule

bind binary_trie_max_xor_top btmx_check u_btmx_check (.*);

`default_nettype wire
